FILE: design/rrt_pkg.sv
package rrt_pkg;

    localparam int OUT_W = 9;

    localparam logic [1:0] ACT_CREATE    = 2'd0;
    localparam logic [1:0] ACT_TERMINATE = 2'd1;
    localparam logic [1:0] ACT_YIELD     = 2'd2;

    localparam logic [1:0] SLOT_READY      = 2'd0;
    localparam logic [1:0] SLOT_RUNNING    = 2'd1;
    localparam logic [1:0] SLOT_TERMINATED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM_CHK,
        ST_SCAN,
        ST_SWAP_CHK,
        ST_SWAP_SET,
        ST_FINISH
    } state_t;

endpackage

FILE: design/rrt_req_if.sv
interface rrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] target_slot;

    modport source (output valid, output action, output target_slot, input ready);
    modport sink   (input valid, input action, input target_slot, output ready);
endinterface

FILE: design/rrt_rsp_if.sv
interface rrt_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [rrt_pkg::OUT_W-1:0] new_task_id;
    logic [rrt_pkg::OUT_W-1:0] current_id;
    logic                     switched;
    logic [rrt_pkg::OUT_W-1:0] live_count;
    logic                     rejected;

    modport source (output valid, output new_task_id, output current_id, output switched,
                    output live_count, output rejected, input ready);
    modport sink   (input valid, input new_task_id, input current_id, input switched,
                    input live_count, input rejected, output ready);
endinterface

FILE: design/rrt_ram.sv
module rrt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/round_robin_task_table_unit.sv
// Round-robin task table. Each request creates a task, terminates a task or
// yields to the next ready task, and returns one response carrying the
// current task id and the live task count. Slot states sit in a single-port
// read, single-port write RAM and every lookup goes through its registered
// read port: terminate reads the slot state before it marks it terminated,
// and yield searches for a ready slot, reading one slot per cycle downward
// from just below the current slot (from the newest if none) round to it.
// A request is taken only while the unit is idle; a finished response waits
// in the output register and does not hold off the next request.
module round_robin_task_table_unit #(
    parameter int TASK_SLOTS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    rrt_req_if.sink      req,
    rrt_rsp_if.source    rsp
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int TW = (CW > 8) ? CW : 8;
    localparam int OW = rrt_pkg::OUT_W;

    rrt_pkg::state_t state_reg, state_next;

    logic [CW-1:0] slots_used_reg, slots_used_next;
    logic [CW-1:0] live_reg, live_next;
    logic [IW-1:0] current_reg, current_next;
    logic          present_reg, present_next;

    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] scan_rem_reg, scan_rem_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [IW-1:0] target_reg, target_next;

    logic [OW-1:0] res_new_id_reg, res_new_id_next;
    logic          res_switched_reg, res_switched_next;
    logic          res_rejected_reg, res_rejected_next;

    logic          out_valid_reg, out_valid_next;
    logic [OW-1:0] out_new_id_reg, out_new_id_next;
    logic [OW-1:0] out_current_reg, out_current_next;
    logic          out_switched_reg, out_switched_next;
    logic [OW-1:0] out_live_reg, out_live_next;
    logic          out_rejected_reg, out_rejected_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [1:0]    mem_rdata;

    logic [IW-1:0] last_idx;
    logic          accept;

    rrt_ram #(
        .WIDTH (2),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign last_idx  = IW'(slots_used_reg - CW'(1));
    assign req.ready = (state_reg == rrt_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.new_task_id = out_new_id_reg;
    assign rsp.current_id  = out_current_reg;
    assign rsp.switched    = out_switched_reg;
    assign rsp.live_count  = out_live_reg;
    assign rsp.rejected    = out_rejected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrt_pkg::ST_IDLE;
            slots_used_reg <= '0;
            live_reg       <= '0;
            current_reg    <= '0;
            present_reg    <= 1'b0;
            chk_valid_reg  <= 1'b0;
            scan_rem_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            live_reg       <= live_next;
            current_reg    <= current_next;
            present_reg    <= present_next;
            chk_valid_reg  <= chk_valid_next;
            scan_rem_reg   <= scan_rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg     <= scan_idx_next;
        chk_idx_reg      <= chk_idx_next;
        pick_reg         <= pick_next;
        target_reg       <= target_next;
        res_new_id_reg   <= res_new_id_next;
        res_switched_reg <= res_switched_next;
        res_rejected_reg <= res_rejected_next;
        out_new_id_reg   <= out_new_id_next;
        out_current_reg  <= out_current_next;
        out_switched_reg <= out_switched_next;
        out_live_reg     <= out_live_next;
        out_rejected_reg <= out_rejected_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        slots_used_next   = slots_used_reg;
        live_next         = live_reg;
        current_next      = current_reg;
        present_next      = present_reg;
        scan_idx_next     = scan_idx_reg;
        scan_rem_next     = scan_rem_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        pick_next         = pick_reg;
        target_next       = target_reg;
        res_new_id_next   = res_new_id_reg;
        res_switched_next = res_switched_reg;
        res_rejected_next = res_rejected_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_new_id_next   = out_new_id_reg;
        out_current_next  = out_current_reg;
        out_switched_next = out_switched_reg;
        out_live_next     = out_live_reg;
        out_rejected_next = out_rejected_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = rrt_pkg::SLOT_READY;
        mem_raddr         = '0;

        case (state_reg)
            rrt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_new_id_next   = '0;
                    res_switched_next = 1'b0;
                    res_rejected_next = 1'b0;
                    target_next       = IW'(req.target_slot);
                    state_next        = rrt_pkg::ST_FINISH;
                    case (req.action)
                        rrt_pkg::ACT_CREATE:
                        begin
                            if (slots_used_reg >= CW'(TASK_SLOTS))
                            begin
                                res_rejected_next = 1'b1;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = IW'(slots_used_reg);
                                mem_wdata       = rrt_pkg::SLOT_READY;
                                slots_used_next = slots_used_reg + CW'(1);
                                live_next       = live_reg + CW'(1);
                                res_new_id_next = OW'(slots_used_reg + CW'(1));
                            end
                        end
                        rrt_pkg::ACT_TERMINATE:
                        begin
                            if (TW'(req.target_slot) >= TW'(slots_used_reg))
                            begin
                                res_rejected_next = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = IW'(req.target_slot);
                                state_next = rrt_pkg::ST_TERM_CHK;
                            end
                        end
                        rrt_pkg::ACT_YIELD:
                        begin
                            state_next = rrt_pkg::ST_SCAN;
                            if (!present_reg)
                            begin
                                scan_idx_next = last_idx;
                                scan_rem_next = slots_used_reg;
                            end
                            else if (CW'(current_reg) >= slots_used_reg
                                     || slots_used_reg <= CW'(1))
                            begin
                                scan_rem_next = '0;
                            end
                            else
                            begin
                                scan_idx_next = (current_reg == '0) ? last_idx
                                                : current_reg - IW'(1);
                                scan_rem_next = slots_used_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rrt_pkg::ST_TERM_CHK:
            begin
                if (mem_rdata != rrt_pkg::SLOT_TERMINATED && live_reg != '0)
                begin
                    live_next = live_reg - CW'(1);
                end
                mem_we     = 1'b1;
                mem_waddr  = target_reg;
                mem_wdata  = rrt_pkg::SLOT_TERMINATED;
                state_next = rrt_pkg::ST_FINISH;
            end
            rrt_pkg::ST_SCAN:
            begin
                if (chk_valid_reg && mem_rdata == rrt_pkg::SLOT_READY)
                begin
                    pick_next = chk_idx_reg;
                    if (present_reg)
                    begin
                        mem_raddr  = current_reg;
                        state_next = rrt_pkg::ST_SWAP_CHK;
                    end
                    else
                    begin
                        state_next = rrt_pkg::ST_SWAP_SET;
                    end
                end
                else if (scan_rem_reg != '0)
                begin
                    mem_raddr      = scan_idx_reg;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                    scan_rem_next  = scan_rem_reg - CW'(1);
                    scan_idx_next  = (scan_idx_reg == '0) ? last_idx
                                     : scan_idx_reg - IW'(1);
                end
                else if (!chk_valid_reg)
                begin
                    state_next = rrt_pkg::ST_FINISH;
                end
            end
            rrt_pkg::ST_SWAP_CHK:
            begin
                if (mem_rdata == rrt_pkg::SLOT_RUNNING)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = current_reg;
                    mem_wdata = rrt_pkg::SLOT_READY;
                end
                state_next = rrt_pkg::ST_SWAP_SET;
            end
            rrt_pkg::ST_SWAP_SET:
            begin
                mem_we            = 1'b1;
                mem_waddr         = pick_reg;
                mem_wdata         = rrt_pkg::SLOT_RUNNING;
                current_next      = pick_reg;
                present_next      = 1'b1;
                res_switched_next = 1'b1;
                state_next        = rrt_pkg::ST_FINISH;
            end
            rrt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_new_id_next   = res_new_id_reg;
                    out_current_next  = present_reg ? OW'(CW'(current_reg) + CW'(1)) : '0;
                    out_switched_next = res_switched_reg;
                    out_live_next     = OW'(live_reg);
                    out_rejected_next = res_rejected_reg;
                    state_next        = rrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrt_pkg::ST_IDLE;
            end
        endcase
    end

    a_live_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= slots_used_reg)
        else $error("live count exceeds slots handed out");

    a_current_is_used: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg |-> CW'(current_reg) < slots_used_reg)
        else $error("current task outside used slots");

    a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> slots_used_reg >= $past(slots_used_reg))
        else $error("slot count went backwards");

    a_idle_write_is_create: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrt_pkg::ST_IDLE && mem_we)
            |-> (accept && req.action == rrt_pkg::ACT_CREATE))
        else $error("slot table written while idle without create");

    a_switch_moves_current: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rrt_pkg::ST_SWAP_SET |=> present_reg && res_switched_reg)
        else $error("task switch did not set current task");

endmodule
